// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the envelope sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition never holds on a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== sv/psgadsr_pkg.sv =====
// Types and constants of the PSG ADSR envelope sequencer.
package psgadsr_pkg;

    localparam logic [3:0] FRAME_RELOAD = 4'd14;
    localparam logic [7:0] SUSTAIN_WAIT = 8'd7;
    localparam logic [3:0] ENV_DIR_INC  = 4'd8;
    localparam logic [11:0] ECHO_ROUND  = 12'hFF;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_NOTE_OFF = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        PH_RELEASE = 2'd0,
        PH_SUSTAIN = 2'd1,
        PH_DECAY   = 2'd2,
        PH_ATTACK  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        GO_STEP = 2'd0,
        GO_DONE = 2'd1,
        GO_OFF  = 2'd2
    } t_go;

    // Envelope values that one frame tick works on.
    typedef struct packed {
        t_phase      phase;
        logic [7:0]  volume;
        logic [7:0]  step;
        logic        echo_on;
        logic        vol_flag;
        logic [3:0]  nib;
        t_go         go;
    } t_work;

    // Values that stay fixed for the whole frame tick.
    typedef struct packed {
        logic [3:0] peak;
        logic [3:0] hold;
        logic [2:0] attack;
        logic [2:0] decay;
        logic [3:0] sustain;
        logic [2:0] release_rate;
        logic [3:0] echo_scaled;
        logic       wave;
    } t_ctx;

endpackage

// ===== sv/psg_adsr_envelope_sequencer.sv =====
// Top level of the PSG ADSR envelope sequencer with pseudo-echo.
// One input word is a note on, a note off or a frame tick; each gives exactly one result
// word. An accepted word sits in an input register, and the whole envelope update,
// including the double step on every fifteenth frame, is done by one pass of combinational
// logic into the channel state and the result register. A word is accepted on every cycle
// while results are taken. An accepted word passes through the input register and then the
// single update path into the result register, where its result becomes valid. While
// a finished result waits for the sink, the input register takes one more word and then
// holds the input side off. The wave_mode register is written over its own channel; the user
// must write it only while no word is in flight, which the block itself does not enforce.
`include "assert_macros.svh"

module psg_adsr_envelope_sequencer
    import psgadsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data,     // wave_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // attack_rate, decay_rate, sustain_level, release_rate, echo_volume,
    // echo_frames, peak_goal, hold_goal, zero fill
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // env_volume, step_nibble, volume_write, osc_off, active, zero fill
    output logic [15:0] m_axis_tdata
);

    // Configuration
    logic r_wave;

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_req;
    logic [39:0] r_in_data;

    // Channel state
    t_phase      r_phase;
    logic        r_start_pend;
    logic        r_stop_pend;
    logic        r_echo_on;
    logic        r_sounding;
    logic [7:0]  r_volume;
    logic [7:0]  r_step;
    logic [7:0]  r_echo_left;
    logic [3:0]  r_frame;
    logic [3:0]  r_nibble;
    logic [2:0]  r_attack;
    logic [2:0]  r_decay;
    logic [3:0]  r_sustain;
    logic [2:0]  r_release;
    logic [7:0]  r_echo_vol;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_out_data;

    // Next values
    t_phase      n_phase;
    logic        n_start_pend;
    logic        n_stop_pend;
    logic        n_echo_on;
    logic        n_sounding;
    logic [7:0]  n_volume;
    logic [7:0]  n_step;
    logic [7:0]  n_echo_left;
    logic [3:0]  n_frame;
    logic [3:0]  n_nibble;
    logic [2:0]  n_attack;
    logic [2:0]  n_decay;
    logic [3:0]  n_sustain;
    logic [2:0]  n_release;
    logic [7:0]  n_echo_vol;
    logic        n_vol_write;
    logic        n_osc_off;

    logic        w_in_accept;
    logic        w_advance;
    logic [3:0]  w_peak;
    logic [3:0]  w_hold;
    logic [11:0] w_echo_sum;

    function automatic logic f_not_positive(logic [7:0] v);
        f_not_positive = (v == 8'd0) || v[7];
    endfunction

    function automatic t_work f_echo_start(t_work w_in, t_ctx c);
        t_work w;
        w = w_in;
        w.volume = {4'd0, c.echo_scaled};
        if (c.echo_scaled == 4'd0) begin
            w.go = GO_OFF;
        end else begin
            w.echo_on  = 1'b1;
            w.vol_flag = 1'b1;
            if (!c.wave) begin
                w.nib = ENV_DIR_INC;
            end
            w.go = GO_DONE;
        end
        return w;
    endfunction

    // Only reached from the decay phase; the phase moves on to sustain, or to release when sustain is zero.
    function automatic t_work f_sustain_start(t_work w_in, t_ctx c);
        t_work w;
        w = w_in;
        if (c.sustain == 4'd0) begin
            w.phase = PH_RELEASE;
            w = f_echo_start(w, c);
        end else begin
            w.phase    = PH_SUSTAIN;
            w.vol_flag = 1'b1;
            if (!c.wave) begin
                w.nib = ENV_DIR_INC;
            end
            w.volume = {4'd0, c.hold};
            w.step   = SUSTAIN_WAIT;
            w.go     = GO_STEP;
        end
        return w;
    endfunction

    function automatic t_work f_decay_start(t_work w_in, t_ctx c);
        t_work w;
        w = w_in;
        w.phase = PH_DECAY;
        w.step  = {5'd0, c.decay};
        if (c.decay == 3'd0) begin
            w = f_sustain_start(w, c);
        end else begin
            w.vol_flag = 1'b1;
            w.volume   = {4'd0, c.peak};
            if (!c.wave) begin
                w.nib = {1'b0, c.decay};
            end
            w.go = GO_STEP;
        end
        return w;
    endfunction

    function automatic t_work f_env_step(t_work w_in, t_ctx c);
        t_work w;
        w = w_in;
        w.go = GO_STEP;
        if (w.step == 8'd0) begin
            if (c.wave) begin
                w.vol_flag = 1'b1;
            end
            case (w.phase)
                PH_RELEASE: begin
                    w.volume = w.volume - 8'd1;
                    if (f_not_positive(w.volume)) begin
                        w = f_echo_start(w, c);
                    end else begin
                        w.step = {5'd0, c.release_rate};
                    end
                end
                PH_SUSTAIN: begin
                    w.volume = {4'd0, c.hold};
                    w.step   = SUSTAIN_WAIT;
                end
                PH_DECAY: begin
                    w.volume = w.volume - 8'd1;
                    // Signed test: a wrapped volume counts as below the hold goal.
                    if (w.volume[7] || (w.volume <= {4'd0, c.hold})) begin
                        w = f_sustain_start(w, c);
                    end else begin
                        w.step = {5'd0, c.decay};
                    end
                end
                default: begin
                    w.volume = w.volume + 8'd1;
                    if (w.volume >= {4'd0, c.peak}) begin
                        w = f_decay_start(w, c);
                    end else begin
                        w.step = {5'd0, c.attack};
                    end
                end
            endcase
        end
        return w;
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_peak     = r_in_data[32:29];
    assign w_hold     = r_in_data[36:33];
    // Pseudo-echo volume, rounded up; never exceeds 15.
    assign w_echo_sum = 12'(w_peak * r_echo_vol) + ECHO_ROUND;

    always_comb begin
        t_work w;
        t_ctx  c;
        logic  doubled;

        n_phase      = r_phase;
        n_start_pend = r_start_pend;
        n_stop_pend  = r_stop_pend;
        n_echo_on    = r_echo_on;
        n_sounding   = r_sounding;
        n_volume     = r_volume;
        n_step       = r_step;
        n_echo_left  = r_echo_left;
        n_frame      = r_frame;
        n_nibble     = r_nibble;
        n_attack     = r_attack;
        n_decay      = r_decay;
        n_sustain    = r_sustain;
        n_release    = r_release;
        n_echo_vol   = r_echo_vol;
        n_vol_write  = 1'b0;
        n_osc_off    = 1'b0;

        c.peak         = w_peak;
        c.hold         = w_hold;
        c.attack       = r_attack;
        c.decay        = r_decay;
        c.sustain      = r_sustain;
        c.release_rate = r_release;
        c.echo_scaled  = w_echo_sum[11:8];
        c.wave         = r_wave;

        w.phase    = r_phase;
        w.volume   = r_volume;
        w.step     = r_step;
        w.echo_on  = r_echo_on;
        w.vol_flag = 1'b0;
        w.nib      = r_nibble;
        w.go       = GO_DONE;

        n_frame = (r_frame != 4'd0) ? (r_frame - 4'd1) : FRAME_RELOAD;
        doubled = (n_frame == 4'd0);

        case (t_req'(r_in_req))
            REQ_NOTE_ON: begin
                n_frame      = r_frame;
                n_attack     = r_in_data[2:0];
                n_decay      = r_in_data[5:3];
                n_sustain    = r_in_data[9:6];
                n_release    = r_in_data[12:10];
                n_echo_vol   = r_in_data[20:13];
                n_echo_left  = r_in_data[28:21];
                n_phase      = PH_RELEASE;
                n_start_pend = 1'b1;
                n_stop_pend  = 1'b0;
                n_echo_on    = 1'b0;
                n_sounding   = 1'b1;
            end
            REQ_NOTE_OFF: begin
                n_frame = r_frame;
                if (r_sounding) begin
                    n_stop_pend = 1'b1;
                end
            end
            REQ_TICK: begin
                if (r_sounding) begin
                    if (r_start_pend) begin
                        if (r_stop_pend) begin
                            w.go = GO_OFF;
                        end else begin
                            w.phase    = PH_ATTACK;
                            n_start_pend = 1'b0;
                            w.echo_on  = 1'b0;
                            w.vol_flag = 1'b1;
                            if (!r_wave) begin
                                w.nib = {1'b1, r_attack};
                            end
                            w.step = {5'd0, r_attack};
                            if (r_attack != 3'd0) begin
                                w.volume = 8'd0;
                                w.go     = GO_STEP;
                            end else begin
                                w = f_decay_start(w, c);
                            end
                        end
                    end else if (r_echo_on) begin
                        n_echo_left = r_echo_left - 8'd1;
                        w.go = f_not_positive(n_echo_left) ? GO_OFF : GO_DONE;
                    end else if (r_stop_pend && (r_phase != PH_RELEASE)) begin
                        w.phase = PH_RELEASE;
                        w.step  = {5'd0, r_release};
                        if (r_release != 3'd0) begin
                            w.vol_flag = 1'b1;
                            if (!r_wave) begin
                                w.nib = {1'b0, r_release};
                            end
                            w.go = GO_STEP;
                        end else begin
                            w = f_echo_start(w, c);
                        end
                    end else begin
                        w = f_env_step(w, c);
                    end

                    // The step counter runs once per frame, twice on the fifteenth frame.
                    if (w.go == GO_STEP) begin
                        w.step = w.step - 8'd1;
                        if (doubled) begin
                            w = f_env_step(w, c);
                            if (w.go == GO_STEP) begin
                                w.step = w.step - 8'd1;
                            end
                        end
                    end

                    n_volume = w.volume;
                    n_step   = w.step;
                    if (w.go == GO_OFF) begin
                        n_sounding   = 1'b0;
                        n_phase      = PH_RELEASE;
                        n_start_pend = 1'b0;
                        n_stop_pend  = 1'b0;
                        n_echo_on    = 1'b0;
                        n_osc_off    = 1'b1;
                    end else begin
                        n_phase     = w.phase;
                        n_echo_on   = w.echo_on;
                        n_vol_write = w.vol_flag;
                        if (w.vol_flag && !r_wave) begin
                            n_nibble = w.nib;
                        end
                    end
                end
            end
            default: begin
                n_frame = r_frame;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave       <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_RELEASE;
            r_start_pend <= 1'b0;
            r_stop_pend  <= 1'b0;
            r_echo_on    <= 1'b0;
            r_sounding   <= 1'b0;
            r_volume     <= 8'd0;
            r_step       <= 8'd0;
            r_echo_left  <= 8'd0;
            r_frame      <= 4'd0;
            r_nibble     <= 4'd0;
            r_attack     <= 3'd0;
            r_decay      <= 3'd0;
            r_sustain    <= 4'd0;
            r_release    <= 3'd0;
            r_echo_vol   <= 8'd0;
        end else begin
            if (i_cfg_valid) begin
                r_wave <= i_cfg_data[0];
            end
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_phase      <= n_phase;
                r_start_pend <= n_start_pend;
                r_stop_pend  <= n_stop_pend;
                r_echo_on    <= n_echo_on;
                r_sounding   <= n_sounding;
                r_volume     <= n_volume;
                r_step       <= n_step;
                r_echo_left  <= n_echo_left;
                r_frame      <= n_frame;
                r_nibble     <= n_nibble;
                r_attack     <= n_attack;
                r_decay      <= n_decay;
                r_sustain    <= n_sustain;
                r_release    <= n_release;
                r_echo_vol   <= n_echo_vol;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_req  <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out_data <= {5'd0, n_sounding, n_osc_off, n_vol_write,
                           (r_wave ? 4'd0 : n_nibble), n_volume[3:0]};
        end
    end

    `ASSERT_CLK(a_frame_range, i_clk, i_rst_n, r_frame <= FRAME_RELOAD)
    `ASSERT_NEVER(a_off_and_write, i_clk, i_rst_n, r_out_valid && r_out_data[8] && r_out_data[9])
    `ASSERT_NEVER(a_off_but_active, i_clk, i_rst_n, r_out_valid && r_out_data[9] && r_out_data[10])
    `ASSERT_CLK(a_state_holds, i_clk, i_rst_n, !w_advance |=> $stable(r_frame) && $stable(r_volume))
    `ASSERT_NEVER(a_pending_silent, i_clk, i_rst_n, !r_sounding && (r_start_pend || r_echo_on))

endmodule
